### rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Pending response tracker package
// Shared codes, entry layout and compare result type for the tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned CONN_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    RES_STORED     = 3'd0,
    RES_REPLACED   = 3'd1,
    RES_FULL       = 3'd2,
    RES_MATCHED    = 3'd3,
    RES_UNMATCHED  = 3'd4,
    RES_SWEEP_DONE = 3'd5
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [CONN_W-1:0]   conn;
    logic [TIME_W-1:0]   sent_time;
    logic [STATUS_W-1:0] status;
  } entry_t;

  typedef struct packed {
    logic id_eq;
    logic status_eq;
    logic conn_eq;
    logic aged;
  } cmp_t;

endpackage

### rtl/prt_in_if.sv
// ----------------------------------------------------------------------------
// Tracker input channel
// Valid/ready channel carrying one request item into the tracker.
// ----------------------------------------------------------------------------
interface prt_in_if;
  logic                          valid;
  logic                          ready;
  logic [prt_pkg::MODE_W-1:0]    mode;
  logic [prt_pkg::ID_W-1:0]      packet_id;
  logic [prt_pkg::STATUS_W-1:0]  packet_status;
  logic [prt_pkg::CONN_W-1:0]    connection_id;
  logic [prt_pkg::TIME_W-1:0]    time_now;

  modport source (output valid, mode, packet_id, packet_status, connection_id, time_now,
                  input ready);
  modport sink   (input valid, mode, packet_id, packet_status, connection_id, time_now,
                  output ready);
endinterface

### rtl/prt_out_if.sv
// ----------------------------------------------------------------------------
// Tracker result channel
// Valid/ready channel carrying one result item out of the tracker.
// ----------------------------------------------------------------------------
interface prt_out_if;
  logic                          valid;
  logic                          ready;
  logic [prt_pkg::CODE_W-1:0]    result_code;
  logic [prt_pkg::ID_W-1:0]      matched_id;
  logic [prt_pkg::CONN_W-1:0]    matched_connection;
  logic [prt_pkg::COUNT_W-1:0]   removed_count;
  logic [prt_pkg::COUNT_W-1:0]   occupancy;

  modport source (output valid, result_code, matched_id, matched_connection,
                  removed_count, occupancy, input ready);
  modport sink   (input valid, result_code, matched_id, matched_connection,
                  removed_count, occupancy, output ready);
endinterface

### rtl/pending_response_tracker_unit.sv
// ----------------------------------------------------------------------------
// Pending response tracker
// Bounded table of outstanding requests with send, receive, timeout tick
// and connection-close handling.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request: send, response received, time tick or
//   connection closed. out_rsp returns exactly one result per request.
//   cfg_write_en/cfg_write_data load timeout_limit; write only while idle.
// Sequencing:
//   Every request sweeps the table through one shared compare unit, one
//   entry per cycle, with the entry memory read issued in the cycle
//   before its compare. After the scan, the finish state commits the table
//   update and sets out_rsp.valid. in_req.ready is high only while idle,
//   so no new request is taken while a request is being scanned or finished.
// Reset:
//   All valid marks and the occupancy count clear at once; timeout_limit
//   returns to 1000. Entry contents are not cleared; they are read on every
//   scan, but only used while their valid mark is set.
// Stall:
//   The result register holds while out_rsp.ready is low. A new request
//   may still be accepted and scanned; it waits in the finish cycle until
//   the held result is taken.
// ----------------------------------------------------------------------------
module pending_response_tracker_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  prt_in_if.sink                        in_req,
  prt_out_if.source                     out_rsp,
  input  logic                          cfg_write_en,
  input  logic [prt_pkg::TIME_W-1:0]    cfg_write_data
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Control state
  prt_pkg::state_t          state_r, state_nxt;
  logic [TABLE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]         occ_r, occ_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     hit_r, hit_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic                     free_r, free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic                     matched_r, matched_nxt;
  logic [CNT_W-1:0]         removed_r, removed_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [prt_pkg::TIME_W-1:0] limit_r;

  // Request and result payload
  prt_pkg::mode_t               req_mode_r;
  logic [prt_pkg::ID_W-1:0]     req_id_r;
  logic [prt_pkg::STATUS_W-1:0] req_status_r;
  logic [prt_pkg::CONN_W-1:0]   req_conn_r;
  logic [prt_pkg::TIME_W-1:0]   req_time_r;
  logic [prt_pkg::CONN_W-1:0]   hit_conn_r, hit_conn_nxt;

  logic [prt_pkg::CODE_W-1:0]   res_code_r, res_code_nxt;
  logic [prt_pkg::ID_W-1:0]     res_id_r, res_id_nxt;
  logic [prt_pkg::CONN_W-1:0]   res_conn_r, res_conn_nxt;
  logic [prt_pkg::COUNT_W-1:0]  res_removed_r, res_removed_nxt;
  logic [prt_pkg::COUNT_W-1:0]  res_occ_r, res_occ_nxt;

  // Memory and compare unit
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  prt_pkg::entry_t          ram_wdata;
  prt_pkg::entry_t          ram_rdata;
  prt_pkg::cmp_t            cmp;

  logic                     in_fire;
  logic                     out_free;
  logic                     rd_entry_valid;
  logic                     store_new;
  logic [CNT_W+prt_pkg::COUNT_W-1:0] removed_ext;
  logic [CNT_W+prt_pkg::COUNT_W-1:0] occ_ext;

  assign in_req.ready = (state_r == prt_pkg::ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign rd_entry_valid = valid_r[rd_idx_r];

  prt_entry_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  prt_cmp_unit u_cmp (
    .entry         (ram_rdata),
    .packet_id     (req_id_r),
    .packet_status (req_status_r),
    .connection_id (req_conn_r),
    .time_now      (req_time_r),
    .timeout_limit (limit_r),
    .cmp           (cmp)
  );

  // Sequencer: next state, table update and result formation.
  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    occ_nxt         = occ_r;
    idx_nxt         = idx_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    matched_nxt     = matched_r;
    removed_nxt     = removed_r;
    hit_conn_nxt    = hit_conn_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    res_code_nxt    = res_code_r;
    res_id_nxt      = res_id_r;
    res_conn_nxt    = res_conn_r;
    res_removed_nxt = res_removed_r;
    res_occ_nxt     = res_occ_r;
    ram_we          = 1'b0;
    ram_waddr       = hit_r ? hit_idx_r : free_idx_r;
    ram_wdata.id        = req_id_r;
    ram_wdata.conn      = req_conn_r;
    ram_wdata.sent_time = req_time_r;
    ram_wdata.status    = req_status_r;
    store_new       = (req_mode_r == prt_pkg::MODE_SEND) && !hit_r && free_r;
    removed_ext     = {{prt_pkg::COUNT_W{1'b0}}, removed_r};
    occ_ext         = '0;

    case (state_r)
      prt_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt     = '0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          matched_nxt = 1'b0;
          removed_nxt = '0;
          state_nxt   = prt_pkg::ST_SCAN;
        end
      end

      prt_pkg::ST_SCAN: begin
        // Issue the next read in the cycle before its compare.
        if (idx_r < CNT_W'(TABLE_DEPTH)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt    = CNT_W'(idx_r + 1'b1);
        end else begin
          state_nxt = prt_pkg::ST_FINISH;
        end

        if (rd_vld_r) begin
          case (req_mode_r)
            prt_pkg::MODE_SEND: begin
              if (rd_entry_valid && cmp.id_eq) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = rd_idx_r;
              end
              // Take the lowest free slot.
              if (!rd_entry_valid && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = rd_idx_r;
              end
            end
            prt_pkg::MODE_RECV: begin
              // Ids are unique, so at most one entry matches.
              if (rd_entry_valid && cmp.id_eq && cmp.status_eq) begin
                valid_nxt[rd_idx_r] = 1'b0;
                matched_nxt         = 1'b1;
                hit_conn_nxt        = ram_rdata.conn;
                removed_nxt         = CNT_W'(removed_r + 1'b1);
              end
            end
            prt_pkg::MODE_TICK: begin
              if (rd_entry_valid && cmp.aged) begin
                valid_nxt[rd_idx_r] = 1'b0;
                removed_nxt         = CNT_W'(removed_r + 1'b1);
              end
            end
            prt_pkg::MODE_CLOSE: begin
              if (rd_entry_valid && cmp.conn_eq) begin
                valid_nxt[rd_idx_r] = 1'b0;
                removed_nxt         = CNT_W'(removed_r + 1'b1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      prt_pkg::ST_FINISH: begin
        // Hold here until the result register is free.
        if (out_free) begin
          occ_nxt = CNT_W'(occ_r - removed_r) + CNT_W'(store_new);
          occ_ext = {{prt_pkg::COUNT_W{1'b0}}, occ_nxt};
          res_removed_nxt = removed_ext[prt_pkg::COUNT_W-1:0];
          res_occ_nxt     = occ_ext[prt_pkg::COUNT_W-1:0];
          out_valid_nxt   = 1'b1;
          state_nxt       = prt_pkg::ST_IDLE;

          case (req_mode_r)
            prt_pkg::MODE_SEND: begin
              res_id_nxt   = req_id_r;
              res_conn_nxt = req_conn_r;
              if (hit_r) begin
                res_code_nxt = prt_pkg::RES_REPLACED;
              end else if (free_r) begin
                res_code_nxt = prt_pkg::RES_STORED;
              end else begin
                res_code_nxt = prt_pkg::RES_FULL;
              end
              if (hit_r || free_r) begin
                ram_we = 1'b1;
                valid_nxt[ram_waddr] = 1'b1;
              end
            end
            prt_pkg::MODE_RECV: begin
              res_id_nxt   = req_id_r;
              res_code_nxt = matched_r ? prt_pkg::RES_MATCHED : prt_pkg::RES_UNMATCHED;
              res_conn_nxt = matched_r ? hit_conn_r : '0;
            end
            prt_pkg::MODE_TICK: begin
              res_id_nxt   = '0;
              res_code_nxt = prt_pkg::RES_SWEEP_DONE;
              res_conn_nxt = '0;
            end
            prt_pkg::MODE_CLOSE: begin
              res_id_nxt   = '0;
              res_code_nxt = prt_pkg::RES_SWEEP_DONE;
              res_conn_nxt = req_conn_r;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = prt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prt_pkg::ST_IDLE;
      valid_r     <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      free_r      <= 1'b0;
      free_idx_r  <= '0;
      matched_r   <= 1'b0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= prt_pkg::TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      hit_r       <= hit_nxt;
      hit_idx_r   <= hit_idx_nxt;
      free_r      <= free_nxt;
      free_idx_r  <= free_idx_nxt;
      matched_r   <= matched_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        limit_r <= cfg_write_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode_r   <= prt_pkg::mode_t'(in_req.mode);
      req_id_r     <= in_req.packet_id;
      req_status_r <= in_req.packet_status;
      req_conn_r   <= in_req.connection_id;
      req_time_r   <= in_req.time_now;
    end
    hit_conn_r    <= hit_conn_nxt;
    res_code_r    <= res_code_nxt;
    res_id_r      <= res_id_nxt;
    res_conn_r    <= res_conn_nxt;
    res_removed_r <= res_removed_nxt;
    res_occ_r     <= res_occ_nxt;
  end

  assign out_rsp.valid              = out_valid_r;
  assign out_rsp.result_code        = res_code_r;
  assign out_rsp.matched_id         = res_id_r;
  assign out_rsp.matched_connection = res_conn_r;
  assign out_rsp.removed_count      = res_removed_r;
  assign out_rsp.occupancy          = res_occ_r;

endmodule

### rtl/prt_entry_ram.sv
// ----------------------------------------------------------------------------
// Tracker entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prt_entry_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  prt_pkg::entry_t                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output prt_pkg::entry_t                        rdata
);

  prt_pkg::entry_t mem [DEPTH];
  prt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/prt_cmp_unit.sv
// ----------------------------------------------------------------------------
// Tracker compare unit
// Compares one stored entry against the request under work: id, status,
// connection and wrapped age against the timeout.
// ----------------------------------------------------------------------------
module prt_cmp_unit (
  input  prt_pkg::entry_t                entry,
  input  logic [prt_pkg::ID_W-1:0]       packet_id,
  input  logic [prt_pkg::STATUS_W-1:0]   packet_status,
  input  logic [prt_pkg::CONN_W-1:0]     connection_id,
  input  logic [prt_pkg::TIME_W-1:0]     time_now,
  input  logic [prt_pkg::TIME_W-1:0]     timeout_limit,
  output prt_pkg::cmp_t                  cmp
);

  logic [prt_pkg::TIME_W-1:0] age;

  // Age wraps modulo 2^32.
  assign age = time_now - entry.sent_time;

  always_comb begin
    cmp.id_eq     = (entry.id == packet_id);
    cmp.status_eq = (entry.status == packet_status);
    cmp.conn_eq   = (entry.conn == connection_id);
    cmp.aged      = (age > timeout_limit);
  end

endmodule

### rtl/prt_checker.sv
// ----------------------------------------------------------------------------
// Tracker port checker
// Checks handshake and result consistency seen on the tracker ports.
// ----------------------------------------------------------------------------
module prt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [prt_pkg::CODE_W-1:0]    out_result_code,
  input logic [prt_pkg::ID_W-1:0]      out_matched_id,
  input logic [prt_pkg::CONN_W-1:0]    out_matched_connection,
  input logic [prt_pkg::COUNT_W-1:0]   out_removed_count
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_code) &&
      $stable(out_matched_id) && $stable(out_removed_count))
    else $error("result changed while stalled");

  // The sequencer is busy right after taking a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while sweep in progress");

  // Only defined result codes appear.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_code <= prt_pkg::RES_SWEEP_DONE)
    else $error("undefined result code");

  // A send never removes entries.
  a_send_removes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_code == prt_pkg::RES_STORED ||
      out_result_code == prt_pkg::RES_REPLACED ||
      out_result_code == prt_pkg::RES_FULL) |-> out_removed_count == '0)
    else $error("send result reports removals");

  // An unmatched response removes nothing and names no connection.
  a_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code == prt_pkg::RES_UNMATCHED |->
      out_removed_count == '0 && out_matched_connection == '0)
    else $error("unmatched result inconsistent");

endmodule

bind pending_response_tracker_unit prt_checker u_prt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_req.valid),
  .in_ready               (in_req.ready),
  .out_valid              (out_rsp.valid),
  .out_ready              (out_rsp.ready),
  .out_result_code        (out_rsp.result_code),
  .out_matched_id         (out_rsp.matched_id),
  .out_matched_connection (out_rsp.matched_connection),
  .out_removed_count      (out_rsp.removed_count)
);

### tb/prt_outcome_checker.sv
// ----------------------------------------------------------------------------
// Pending response tracker outcome checker
// Watches the request, result and timeout write ports, keeps its own copy
// of the pending table and compares every result against its prediction.
// ----------------------------------------------------------------------------
module prt_outcome_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  prt_in_if                          in_mon,
  prt_out_if                         out_mon,
  input  logic                       cfg_write_en,
  input  logic [prt_pkg::TIME_W-1:0] cfg_write_data,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked,
  output int                         removed_total
);

  typedef struct packed {
    prt_pkg::res_t                 code;
    logic [prt_pkg::ID_W-1:0]      id;
    logic [prt_pkg::CONN_W-1:0]    conn;
    logic [prt_pkg::COUNT_W-1:0]   removed;
    logic [prt_pkg::COUNT_W-1:0]   occ;
  } outcome_t;

  bit                           tbl_valid  [TABLE_DEPTH];
  logic [prt_pkg::ID_W-1:0]     tbl_id     [TABLE_DEPTH];
  logic [prt_pkg::CONN_W-1:0]   tbl_conn   [TABLE_DEPTH];
  logic [prt_pkg::TIME_W-1:0]   tbl_sent   [TABLE_DEPTH];
  logic [prt_pkg::STATUS_W-1:0] tbl_status [TABLE_DEPTH];
  logic [prt_pkg::TIME_W-1:0]   timeout_copy;

  outcome_t expected_outcomes [$];
  outcome_t want;

  function automatic int find_slot(input logic [prt_pkg::ID_W-1:0] pid);
    int slot;
    slot = -1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_id[i] == pid) slot = i;
    return slot;
  endfunction

  // Apply one request to the table copy and return the outcome it yields.
  function automatic outcome_t track_request(input prt_pkg::mode_t mode,
                                             input logic [prt_pkg::ID_W-1:0] pid,
                                             input logic [prt_pkg::STATUS_W-1:0] status,
                                             input logic [prt_pkg::CONN_W-1:0] conn,
                                             input logic [prt_pkg::TIME_W-1:0] now);
    outcome_t r;
    int slot;
    int removed;
    int cnt;
    logic [prt_pkg::TIME_W-1:0] age;
    r = '0;
    removed = 0;
    cnt = 0;
    slot = find_slot(pid);
    case (mode)
      prt_pkg::MODE_SEND: begin
        r.id = pid;
        r.conn = conn;
        if (slot >= 0) begin
          r.code = prt_pkg::RES_REPLACED;
        end else begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!tbl_valid[i]) slot = i;
          r.code = (slot >= 0) ? prt_pkg::RES_STORED : prt_pkg::RES_FULL;
        end
        if (slot >= 0) begin
          tbl_valid[slot]  = 1'b1;
          tbl_id[slot]     = pid;
          tbl_conn[slot]   = conn;
          tbl_sent[slot]   = now;
          tbl_status[slot] = status;
        end
      end
      prt_pkg::MODE_RECV: begin
        r.id = pid;
        if (slot >= 0 && tbl_status[slot] == status) begin
          r.code = prt_pkg::RES_MATCHED;
          r.conn = tbl_conn[slot];
          tbl_valid[slot] = 1'b0;
          removed = 1;
        end else begin
          r.code = prt_pkg::RES_UNMATCHED;
        end
      end
      prt_pkg::MODE_TICK: begin
        r.code = prt_pkg::RES_SWEEP_DONE;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          age = now - tbl_sent[i];
          if (tbl_valid[i] && age > timeout_copy) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        end
      end
      default: begin
        r.code = prt_pkg::RES_SWEEP_DONE;
        r.conn = conn;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && tbl_conn[i] == conn) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        end
      end
    endcase
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_valid[i]) cnt++;
    r.removed = prt_pkg::COUNT_W'(removed);
    r.occ = prt_pkg::COUNT_W'(cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      timeout_copy = prt_pkg::TIMEOUT_RESET;
      expected_outcomes.delete();
      fail_count = 0;
      results_checked = 0;
      removed_total = 0;
    end else begin
      if (cfg_write_en) timeout_copy = cfg_write_data;
      // Check results before queueing a new request from the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none actual code %0h id %0h",
                   $time, out_mon.result_code, out_mon.matched_id);
        end else begin
          want = expected_outcomes.pop_front();
          check_field("result_code", 32'(want.code), 32'(out_mon.result_code));
          check_field("matched_id", want.id, out_mon.matched_id);
          check_field("matched_connection", 32'(want.conn), 32'(out_mon.matched_connection));
          check_field("removed_count", 32'(want.removed), 32'(out_mon.removed_count));
          check_field("occupancy", 32'(want.occ), 32'(out_mon.occupancy));
          results_checked++;
          removed_total += int'(want.removed);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_outcomes.push_back(track_request(prt_pkg::mode_t'(in_mon.mode),
                                                  in_mon.packet_id,
                                                  in_mon.packet_status,
                                                  in_mon.connection_id,
                                                  in_mon.time_now));
    end
    pending = expected_outcomes.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Pending response tracker testbench
// Drives directed and random send, receive, tick and close requests into
// the tracker under several timeout settings and idle mixes; a separate
// checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TABLE_DEPTH   = 16;
  // A request holds the tracker from acceptance until its finish state ends.
  localparam int          REQ_LATENCY   = TABLE_DEPTH + 3;
  localparam int          SETTLE_CYCLES = 2 * REQ_LATENCY;
  localparam int          PHASES        = 6;
  localparam int          PER_PHASE     = 325;
  localparam int          RING          = 16;
  localparam int          HOLD_CYCLES   = 400;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_write_en;
  logic [prt_pkg::TIME_W-1:0]   cfg_write_data;

  prt_in_if  req_ch ();
  prt_out_if rsp_ch ();

  int fail_count;
  int pending;
  int results_checked;
  int removed_total;

  // Idle percentages for the sender and the receiver, and a one-shot
  // request for a long receiver hold-off.
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_len;
  int issued;

  // Recently sent ids and statuses, used to build well-formed receives.
  logic [prt_pkg::ID_W-1:0]     recent_id     [RING];
  logic [prt_pkg::STATUS_W-1:0] recent_status [RING];
  int                           ring_wr;
  logic [prt_pkg::ID_W-1:0]     id_base;
  logic [prt_pkg::TIME_W-1:0]   cur_time;
  logic [prt_pkg::TIME_W-1:0]   phase_limit;

  pending_response_tracker_unit #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req         (req_ch),
    .out_rsp        (rsp_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  prt_outcome_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (req_ch),
    .out_mon         (rsp_ch),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .removed_total   (removed_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run; a hang anywhere ends up here.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: drop ready at random, or hold it low for a long stretch
  // when asked, so the tracker fills up and stalls its request input.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offer one request after a random idle gap and hold it until accepted.
  // Valid is left high on return so back-to-back requests never toggle it.
  task automatic issue_request(input prt_pkg::mode_t mode,
                               input logic [prt_pkg::ID_W-1:0] pid,
                               input logic [prt_pkg::STATUS_W-1:0] status,
                               input logic [prt_pkg::CONN_W-1:0] conn,
                               input logic [prt_pkg::TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= mode;
    req_ch.packet_id     <= pid;
    req_ch.packet_status <= status;
    req_ch.connection_id <= conn;
    req_ch.time_now      <= now;
    do @(posedge clk); while (!req_ch.ready);
    issued++;
  endtask

  // Drop valid, wait for every outstanding result, then let the tracker
  // drain its pipeline before touching the timeout register.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [prt_pkg::TIME_W-1:0] value);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Build one random request. Ids come from a small per-phase pool so that
  // replaces, full tables and matches happen often; most receives echo a
  // recent send, the rest carry a wrong status or an unknown id.
  task automatic issue_random();
    prt_pkg::mode_t               m;
    logic [prt_pkg::ID_W-1:0]     pid;
    logic [prt_pkg::STATUS_W-1:0] st;
    logic [prt_pkg::CONN_W-1:0]   cn;
    logic [prt_pkg::TIME_W-1:0]   now;
    int                           pick;
    int                           slot;
    pick = $urandom_range(99);
    cur_time = cur_time + prt_pkg::TIME_W'($urandom_range(0, 60));
    now = cur_time;
    cn = ($urandom_range(9) == 0) ? prt_pkg::CONN_W'($urandom)
                                  : prt_pkg::CONN_W'($urandom_range(0, 3));
    st = ($urandom_range(4) == 0) ? prt_pkg::STATUS_W'($urandom)
                                  : prt_pkg::STATUS_W'($urandom_range(0, 3));
    pid = id_base ^ prt_pkg::ID_W'($urandom_range(0, 23));
    if (pick < 45) begin
      m = prt_pkg::MODE_SEND;
      if ($urandom_range(19) == 0) now = $urandom;
      recent_id[ring_wr] = pid;
      recent_status[ring_wr] = st;
      ring_wr = (ring_wr + 1) % RING;
    end else if (pick < 75) begin
      m = prt_pkg::MODE_RECV;
      slot = $urandom_range(0, RING - 1);
      pick = $urandom_range(99);
      if (pick < 70) begin
        pid = recent_id[slot];
        st  = recent_status[slot];
      end else if (pick < 85) begin
        pid = recent_id[slot];
        st  = recent_status[slot] + 8'd1;
      end else begin
        pid = $urandom;
      end
    end else if (pick < 90) begin
      m = prt_pkg::MODE_TICK;
      // A stray time now and then exercises wrapped ages in both directions.
      if ($urandom_range(9) == 0) now = $urandom;
    end else begin
      m = prt_pkg::MODE_CLOSE;
    end
    issue_request(m, pid, st, cn, now);
  endtask

  initial begin
    // Hold every input at a known value through reset.
    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.mode          = prt_pkg::MODE_SEND;
    req_ch.packet_id     = '0;
    req_ch.packet_status = '0;
    req_ch.connection_id = '0;
    req_ch.time_now      = '0;
    cfg_write_en         = 1'b0;
    cfg_write_data       = '0;
    snd_idle_pct         = 11;
    rcv_idle_pct         = 76;
    hold_len             = 0;
    issued               = 0;
    ring_wr              = 0;
    for (int i = 0; i < RING; i++) begin
      recent_id[i]     = '0;
      recent_status[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // Directed part, at the reset timeout of 1000.
    // Empty table: unknown receive, sweeps with nothing to drop.
    issue_request(prt_pkg::MODE_RECV, 32'h0, 8'h00, 8'h00, 32'h0);
    issue_request(prt_pkg::MODE_TICK, 32'h0, 8'h00, 8'h00, 32'hFFFF_FFFF);
    issue_request(prt_pkg::MODE_CLOSE, 32'h0, 8'h00, 8'hFF, 32'h0);
    // Field extremes, then a send that overwrites the entry of its id.
    issue_request(prt_pkg::MODE_SEND, 32'h0, 8'h00, 8'h00, 32'h0);
    issue_request(prt_pkg::MODE_SEND, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    issue_request(prt_pkg::MODE_SEND, 32'h0, 8'h05, 8'h01, 32'd10);
    // Status mismatch leaves the entry, the right status removes it.
    issue_request(prt_pkg::MODE_RECV, 32'h0, 8'h00, 8'h00, 32'd20);
    issue_request(prt_pkg::MODE_RECV, 32'h0, 8'h05, 8'h00, 32'd30);
    // Fill the remaining slots, then overflow the table.
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      issue_request(prt_pkg::MODE_SEND, 32'(i + 16), 8'(i), 8'h02, 32'd500);
    issue_request(prt_pkg::MODE_SEND, 32'd99, 8'h00, 8'h02, 32'd500);
    // Tick at 1500: the entry sent at all-ones has a wrapped age of 1501 and
    // goes; entries sent at 500 sit exactly at the limit and stay.
    issue_request(prt_pkg::MODE_TICK, 32'h0, 8'h00, 8'h00, 32'd1500);
    // Close the connection of the fill entries.
    issue_request(prt_pkg::MODE_CLOSE, 32'h0, 8'h00, 8'h02, 32'd1600);

    // Random part: one timeout setting per phase, extremes among them.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       phase_limit = 32'd200;
        1:       phase_limit = 32'hFFFF_FFFF;
        2:       phase_limit = 32'd0;
        3:       phase_limit = prt_pkg::TIMEOUT_RESET;
        4:       phase_limit = prt_pkg::TIME_W'($urandom_range(50, 3000));
        default: phase_limit = 32'd5000;
      endcase
      write_timeout(phase_limit);
      // Sender mostly busy first, then receiver mostly busy, then no idling.
      snd_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 76 : 0;
      rcv_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 11 : 0;
      id_base  = $urandom;
      // Start one phase just below the wrap point of the time counter.
      cur_time = (ph == 2) ? 32'hFFFF_F000 : prt_pkg::TIME_W'($urandom);
      // Stall the result side for a long stretch while requests keep coming.
      if (ph == 1 || ph == 4) hold_len = HOLD_CYCLES;
      repeat (PER_PHASE) issue_random();
    end
    settle();

    $display("summary: %0d requests over %0d timeout settings, three idle mixes, two long stalls",
             issued, PHASES + 1);
    $display("summary: %0d results checked, %0d table entries removed",
             results_checked, removed_total);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/prt_pkg.sv
rtl/prt_in_if.sv
rtl/prt_out_if.sv
rtl/prt_entry_ram.sv
rtl/prt_cmp_unit.sv
rtl/pending_response_tracker_unit.sv
rtl/prt_checker.sv
tb/prt_outcome_checker.sv
tb/testbench.sv
